// ===== rtl/pmmd_pkg.sv =====
// Shared types and constants for the predictive mean match donor core.
`default_nettype none

package pmmd_pkg;

   // Field widths fixed by the request and response formats
   localparam int SAMPLE_W      = 32;
   localparam int RANK_W        = 5;
   localparam int NEIGHBOUR_W   = 5;
   localparam int DONOR_INDEX_W = 11;
   localparam int DIST_W        = 32;

   // Reset value of the neighbour count register
   localparam logic [NEIGHBOUR_W-1:0] NEIGHBOUR_RESET = 5'd5;

   // Operation codes; code 3 is unused and ignored
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]               operation;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [RANK_W-1:0]        donor_rank;
   } pmmd_req_type;

   typedef struct packed {
      logic [DONOR_INDEX_W-1:0] donor_index;
      logic                     store_empty;
   } pmmd_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/predictive_mean_match_donor_core.sv =====
// Predictive mean match donor core: value store, k-th distance pass and donor pick pass.
//
// Clear and load requests may arrive every cycle while no query runs; a load
// appends a signed Q16.16 value to a store of MAX_OBSERVED entries held in one RAM.
// A query runs two passes that stream the store through the single RAM read port at
// one entry per cycle, the first keeping the MAX_NEIGHBOURS smallest distances in a
// sorted row of registers, the second stopping at the donor, so it may end early.
// A query on an empty store skips both passes. The core accepts no request while a
// query runs; a response held by a stalled consumer does not block clear and load
// requests.
`default_nettype none

module predictive_mean_match_donor_core
   import pmmd_pkg::*;
#(
   parameter int MAX_OBSERVED   = 1024,
   parameter int MAX_NEIGHBOURS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pmmd_req_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pmmd_rsp_type                rsp_data,
   input  wire logic                   csr_we,
   input  wire logic [NEIGHBOUR_W-1:0] csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_OBSERVED + 1);
   localparam int IDX_W  = (MAX_OBSERVED > 1) ? $clog2(MAX_OBSERVED) : 1;
   localparam int KW     = $clog2(MAX_NEIGHBOURS + 1);
   localparam int SLOT_W = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
   localparam int EW_A   = (CNT_W > KW) ? CNT_W : KW;
   localparam int EW     = (EW_A > NEIGHBOUR_W) ? EW_A : NEIGHBOUR_W;
   localparam int PW     = (IDX_W + 1 > DONOR_INDEX_W) ? IDX_W + 1 : DONOR_INDEX_W;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_SCAN_KTH  = 4'b0010,
      ST_SCAN_PICK = 4'b0100,
      ST_FINISH    = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [NEIGHBOUR_W-1:0]    neighbour_ff, neighbour_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          addr_ff, addr_in;
   logic signed [SAMPLE_W-1:0] query_ff, query_in;
   logic [KW-1:0]             k_ff, k_in;
   logic [KW-1:0]             rank_ff, rank_in;
   logic [KW-1:0]             cnt_ff, cnt_in;
   logic [DIST_W-1:0]         dk_ff, dk_in;
   logic                      rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic                      dist_vld_ff, dist_vld_in;
   logic [IDX_W-1:0]          dist_idx_ff, dist_idx_in;
   logic [DIST_W-1:0]         dist_ff, dist_in;
   logic [IDX_W-1:0]          pick_ff, pick_in;
   logic                      empty_ff, empty_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   pmmd_rsp_type              rsp_data_ff, rsp_data_in;
   logic [DIST_W-1:0]         best_ff [MAX_NEIGHBOURS];
   logic [DIST_W-1:0]         best_in [MAX_NEIGHBOURS];
   logic [MAX_NEIGHBOURS-1:0] best_vld_ff, best_vld_in;

   logic                      req_accept;
   logic                      ram_we;
   logic                      issue;
   logic [SAMPLE_W-1:0]       rd_data;
   logic [SAMPLE_W:0]         diff_a, diff_b;
   logic [EW-1:0]             k_req, k_lim, k_sat, k_eff, rank_req, rank_eff;
   logic [KW-1:0]             k_m1;
   logic [MAX_NEIGHBOURS-1:0] above;
   logic                      hit;
   logic [KW-1:0]             cnt_inc;
   logic                      found;
   logic                      pipe_empty;
   logic [PW-1:0]             pick_sum;

   // Handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // Store write on load while room remains
   assign ram_we = req_accept && (req_data.operation == OP_LOAD) &&
                   (count_ff < CNT_W'(MAX_OBSERVED));

   // One read per cycle during either pass
   assign issue = ((state_ff == ST_SCAN_KTH) || (state_ff == ST_SCAN_PICK)) &&
                  (addr_ff < count_ff);

   pmmd_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_OBSERVED)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_data.sample_value),
      .rd_en   (issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Effective k and donor rank, taken at query accept
   always_comb begin
      k_req    = EW'(neighbour_ff);
      k_lim    = (k_req > EW'(MAX_NEIGHBOURS)) ? EW'(MAX_NEIGHBOURS) : k_req;
      k_sat    = (k_lim > EW'(count_ff)) ? EW'(count_ff) : k_lim;
      k_eff    = (k_sat == '0) ? EW'(1) : k_sat;
      rank_req = EW'(req_data.donor_rank);
      rank_eff = (rank_req == '0) ? EW'(1) : rank_req;
      rank_eff = (rank_eff > k_eff) ? k_eff : rank_eff;
   end

   // Absolute distance: both differences in parallel, pick the non-negative one
   assign diff_a = {rd_data[SAMPLE_W-1], rd_data} - {query_ff[SAMPLE_W-1], query_ff};
   assign diff_b = {query_ff[SAMPLE_W-1], query_ff} - {rd_data[SAMPLE_W-1], rd_data};
   assign dist_in = diff_a[SAMPLE_W] ? diff_b[DIST_W-1:0] : diff_a[DIST_W-1:0];

   // Sorted insertion row: each slot looks at itself and its left neighbor
   always_comb begin
      for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
         above[j] = !best_vld_ff[j] || (best_ff[j] > dist_ff);
      end
   end

   // Second pass compare
   assign hit     = (dist_ff <= dk_ff);
   assign cnt_inc = cnt_ff + KW'(1);
   assign found   = dist_vld_ff && hit && (cnt_inc == rank_ff);

   assign pipe_empty = !issue && !rd_vld_ff && !dist_vld_ff;
   assign k_m1       = k_ff - KW'(1);
   assign pick_sum   = PW'(pick_ff) + PW'(1);

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      neighbour_in = csr_we ? csr_wdata : neighbour_ff;
      count_in     = count_ff;
      addr_in      = issue ? addr_ff + CNT_W'(1) : addr_ff;
      query_in     = query_ff;
      k_in         = k_ff;
      rank_in      = rank_ff;
      cnt_in       = cnt_ff;
      dk_in        = dk_ff;
      rd_vld_in    = issue;
      rd_idx_in    = addr_ff[IDX_W-1:0];
      dist_vld_in  = rd_vld_ff;
      dist_idx_in  = rd_idx_ff;
      pick_in      = pick_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      best_in      = best_ff;
      best_vld_in  = best_vld_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.operation)
                  OP_CLEAR: count_in = '0;
                  OP_LOAD: begin
                     if (ram_we) begin
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  OP_QUERY: begin
                     query_in    = req_data.sample_value;
                     k_in        = k_eff[KW-1:0];
                     rank_in     = rank_eff[KW-1:0];
                     addr_in     = '0;
                     best_vld_in = '0;
                     pick_in     = '0;
                     empty_in    = (count_ff == '0);
                     state_in    = (count_ff == '0) ? ST_FINISH : ST_SCAN_KTH;
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN_KTH: begin
            if (dist_vld_ff) begin
               for (int j = 0; j < MAX_NEIGHBOURS; j++) begin
                  if (above[j]) begin
                     if (j > 0 && above[(j > 0) ? j - 1 : 0]) begin
                        best_in[j]     = best_ff[(j > 0) ? j - 1 : 0];
                        best_vld_in[j] = best_vld_ff[(j > 0) ? j - 1 : 0];
                     end else begin
                        best_in[j]     = dist_ff;
                        best_vld_in[j] = 1'b1;
                     end
                  end
               end
            end
            if (pipe_empty) begin
               dk_in    = best_ff[k_m1[SLOT_W-1:0]];
               cnt_in   = '0;
               addr_in  = '0;
               state_in = ST_SCAN_PICK;
            end
         end

         ST_SCAN_PICK: begin
            if (dist_vld_ff && hit) begin
               cnt_in = cnt_inc;
            end
            if (found) begin
               pick_in     = dist_idx_ff;
               rd_vld_in   = 1'b0;
               dist_vld_in = 1'b0;
               state_in    = ST_FINISH;
            end else if (pipe_empty) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.store_empty = empty_ff;
               rsp_data_in.donor_index = empty_ff ? '0 : pick_sum[DONOR_INDEX_W-1:0];
               state_in                = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         neighbour_ff <= NEIGHBOUR_RESET;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         dist_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         best_vld_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         neighbour_ff <= neighbour_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         dist_vld_ff  <= dist_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         best_vld_ff  <= best_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      query_ff    <= query_in;
      k_ff        <= k_in;
      rank_ff     <= rank_in;
      cnt_ff      <= cnt_in;
      dk_ff       <= dk_in;
      rd_idx_ff   <= rd_idx_in;
      dist_idx_ff <= dist_idx_in;
      dist_ff     <= dist_in;
      pick_ff     <= pick_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
      best_ff     <= best_in;
   end

   // Assertions
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish state");

   a_pick_below_rank: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_PICK) |-> (cnt_ff < rank_ff))
      else $error("qualifying count passed donor rank");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN_KTH) || (state_ff == ST_SCAN_PICK)) |-> (count_ff != '0))
      else $error("scan running on empty store");

   for (genvar g = 0; g < MAX_NEIGHBOURS - 1; g++) begin : g_sorted
      a_sorted: assert property (@(posedge clock) disable iff (reset)
         best_vld_ff[g+1] |-> (best_vld_ff[g] && (best_ff[g] <= best_ff[g+1])))
         else $error("nearest distance row out of order");
   end

endmodule

`default_nettype wire

// ===== rtl/pmmd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module pmmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
